@@ rtl/csr_sparse_matvec_core_macros.svh @@
// Assertion macros for the checker of the sparse matrix-vector core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CSR_SPARSE_MATVEC_CORE_MACROS_SVH
`define CSR_SPARSE_MATVEC_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csm check failed");

`endif

@@ rtl/csm_pkg.sv @@
`default_nettype none

package csm_pkg;

    // Default depth of the dense vector store.
    localparam int CSM_VECTOR_DEPTH = 1024;

    localparam int VAL_W   = 16;
    localparam int INDEX_W = 10;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 48;
    localparam int ROW_W   = 16;

    // Request codes.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_NONZERO = 2'd1;
    localparam logic [1:0] REQ_EMPTY   = 2'd2;

    // Accumulator limits, Q17.30.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]               req_type;
        logic [INDEX_W-1:0]       index;
        logic signed [VAL_W-1:0]  value;
        logic                     row_end;
    } csm_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]         row_number;
        logic signed [ACC_W-1:0]  row_sum;
        logic                     saturated;
    } csm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/csr_sparse_matvec_core.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  csm_req_t: req_type, index, value, row_end
// rsp      out        rsp_valid/rsp_stall  csm_rsp_t: row_number, row_sum, saturated
//
// One item is taken per cycle while req_stall is low; a result passes stage 1, stage 2 and the output register.
// The path is vector store read, 16x16 multiply, then 48-bit saturating accumulate.
// rst_n clears control, the accumulator, the row counter and the clip flag at once.
// The vector store has no reset; elements are defined once loaded.
// While a result waits under rsp_stall the whole pipeline holds and req_stall is raised.
`default_nettype none

module csr_sparse_matvec_core import csm_pkg::*; #(
    parameter int VECTOR_DEPTH = CSM_VECTOR_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire csm_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output csm_rsp_t      rsp
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);

    // Dense vector store.
    logic [VAL_W-1:0] vec_mem [VECTOR_DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    logic              advance;
    logic              accept;
    logic [31:0]       idx_ext;
    logic              in_range;
    logic [ADDR_W-1:0] addr;

    // Stage 1: store read in flight.
    logic                    p1_valid_reg;
    logic [1:0]              p1_type_reg;
    logic signed [VAL_W-1:0] p1_val_reg;
    logic                    p1_hit_reg;
    logic                    p1_last_reg;

    // Stage 2: product ready for accumulation.
    logic                     p2_valid_reg;
    logic [1:0]               p2_type_reg;
    logic                     p2_last_reg;
    logic signed [PROD_W-1:0] p2_prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [VAL_W-1:0]  x_elem;

    // Row state.
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    clip_reg, clip_next;
    logic [ROW_W-1:0]        row_cnt_reg, row_cnt_next;

    logic signed [ACC_W:0]   sum_wide;
    logic signed [ACC_W-1:0] sum_sat;
    logic                    sum_clip;
    logic                    close_row;
    logic signed [ACC_W-1:0] close_sum;
    logic                    close_clip;

    logic     out_valid_reg;
    csm_rsp_t out_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance   = !(out_valid_reg && rsp_stall);
    assign accept    = req_valid && advance;
    assign req_stall = !advance;

    // Address decode with the range check against the store depth.
    assign idx_ext  = 32'(req.index);
    assign in_range = idx_ext < 32'(VECTOR_DEPTH);
    assign addr     = idx_ext[ADDR_W-1:0];

    // Store write for loads, registered read for nonzeros.
    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_LOAD && in_range)
        begin
            vec_mem[addr] <= req.value;
        end
        if (accept && req.req_type == REQ_NONZERO)
        begin
            rdata_reg <= vec_mem[addr];
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg  <= req_valid;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg && close_row;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_type_reg <= req.req_type;
            p1_val_reg  <= req.value;
            p1_hit_reg  <= in_range;
            p1_last_reg <= req.row_end;
            p2_type_reg <= p1_type_reg;
            p2_last_reg <= p1_last_reg;
            p2_prod_reg <= prod_next;
        end
    end

    // Multiply; an element beyond the store depth counts as zero.
    assign x_elem    = p1_hit_reg ? $signed(rdata_reg) : '0;
    assign prod_next = p1_val_reg * x_elem;

    // Saturating accumulate.
    assign sum_wide = {acc_reg[ACC_W-1], acc_reg}
                    + {{(ACC_W+1-PROD_W){p2_prod_reg[PROD_W-1]}}, p2_prod_reg};

    always_comb
    begin
        sum_clip = sum_wide[ACC_W] != sum_wide[ACC_W-1];
        if (!sum_clip)
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
        else if (sum_wide[ACC_W])
        begin
            sum_sat = ACC_MIN;
        end
        else
        begin
            sum_sat = ACC_MAX;
        end
    end

    // Row state update per request kind.
    always_comb
    begin
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        row_cnt_next = row_cnt_reg;
        close_row    = 1'b0;
        close_sum    = acc_reg;
        close_clip   = clip_reg;
        case (p2_type_reg)
            REQ_LOAD:
            begin
                row_cnt_next = '0;
            end
            REQ_NONZERO:
            begin
                acc_next   = sum_sat;
                clip_next  = clip_reg || sum_clip;
                close_row  = p2_last_reg;
                close_sum  = sum_sat;
                close_clip = clip_reg || sum_clip;
            end
            REQ_EMPTY:
            begin
                close_row = 1'b1;
            end
            default:
            begin
                close_row = 1'b0;
            end
        endcase
        if (close_row)
        begin
            acc_next     = '0;
            clip_next    = 1'b0;
            row_cnt_next = row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            row_cnt_reg <= '0;
        end
        else if (advance && p2_valid_reg)
        begin
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Output register holds a finished row until its transfer.
    always_ff @(posedge clk)
    begin
        if (advance && p2_valid_reg && close_row)
        begin
            out_reg.row_number <= row_cnt_reg;
            out_reg.row_sum    <= close_sum;
            out_reg.saturated  <= close_clip;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

@@ rtl/csm_checker.sv @@
`default_nettype none

`include "csr_sparse_matvec_core_macros.svh"

module csm_checker import csm_pkg::*; (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_stall,
    input wire csm_req_t req,
    input wire logic     rsp_valid,
    input wire logic     rsp_stall,
    input wire csm_rsp_t rsp
);

    logic empty_xfer;

    // Transfer of an empty-row request.
    assign empty_xfer = req_valid && !req_stall && req.req_type == REQ_EMPTY;

    // A waiting result stays offered with its payload unchanged.
    `CSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    `CSM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp))

    // Input backpressure only comes from a stalled result.
    `CSM_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

    // An empty row reaches the output through stage 1, stage 2 and the output register when unstalled.
    `CSM_ASSERT_NEXT(a_empty_latency, empty_xfer ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind csr_sparse_matvec_core csm_checker u_csm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
